[hw/rtl/pmdc_pkg.sv]
`timescale 1ns / 1ps

package pmdc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ARM_SAFETY_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPRIGHT_WINDOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_LIMIT           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING_DUTY          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING_ARM_THRESHOLD = 3'd4;

  localparam logic CMD_ANGLE  = 1'b0;
  localparam logic CMD_BUTTON = 1'b1;

  localparam logic [1:0] DIR_NONE    = 2'd0;
  localparam logic [1:0] DIR_FORWARD = 2'd1;
  localparam logic [1:0] DIR_REVERSE = 2'd2;
  localparam logic [1:0] DIR_STOP    = 2'd3;

  localparam logic [2:0] PH_ENTRY     = 3'd0;
  localparam logic [2:0] PH_PUSH_FWD  = 3'd1;
  localparam logic [2:0] PH_WAIT_POS  = 3'd2;
  localparam logic [2:0] PH_PUSH_REV  = 3'd3;
  localparam logic [2:0] PH_WAIT_NEG  = 3'd4;

  localparam logic [14:0] RST_ARM_SAFETY_LIMIT    = 15'd600;
  localparam logic [14:0] RST_UPRIGHT_WINDOW      = 15'd90;
  localparam logic [9:0]  RST_PWM_LIMIT           = 10'd795;
  localparam logic [9:0]  RST_SWING_DUTY          = 10'd250;
  localparam logic signed [15:0] RST_SWING_ARM_THRESHOLD = 16'sd32;

  typedef struct packed {
    logic               command;
    logic signed [15:0] pendulum_angle;
    logic signed [15:0] arm_angle_in;
    logic signed [15:0] upright_measure;
    logic               start_pressed;
    logic               stop_pressed;
    logic signed [15:0] drive_request;
  } in_item_t;

  typedef struct packed {
    logic [9:0] pwm_duty;
    logic [1:0] direction;
    logic       direction_valid;
  } out_item_t;

  typedef struct packed {
    logic [14:0]        arm_safety_limit;
    logic [14:0]        upright_window;
    logic [9:0]         pwm_limit;
    logic [9:0]         swing_duty;
    logic signed [15:0] swing_arm_threshold;
  } cfg_t;

endpackage

[hw/rtl/pmdc_cfg.sv]
`timescale 1ns / 1ps

module pmdc_cfg
  import pmdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.arm_safety_limit    <= RST_ARM_SAFETY_LIMIT;
      cfg_r.upright_window      <= RST_UPRIGHT_WINDOW;
      cfg_r.pwm_limit           <= RST_PWM_LIMIT;
      cfg_r.swing_duty          <= RST_SWING_DUTY;
      cfg_r.swing_arm_threshold <= RST_SWING_ARM_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ARM_SAFETY_LIMIT:    cfg_r.arm_safety_limit    <= cfg_wdata[14:0];
        CFG_UPRIGHT_WINDOW:      cfg_r.upright_window      <= cfg_wdata[14:0];
        CFG_PWM_LIMIT:           cfg_r.pwm_limit           <= cfg_wdata[9:0];
        CFG_SWING_DUTY:          cfg_r.swing_duty          <= cfg_wdata[9:0];
        CFG_SWING_ARM_THRESHOLD: cfg_r.swing_arm_threshold <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/pmdc_ctrl.sv]
`timescale 1ns / 1ps

module pmdc_ctrl
  import pmdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res,
  output logic      res_valid
);

  logic               started_r, started_nxt;
  logic signed [15:0] pend_r, pend_nxt;
  logic signed [15:0] arm_r, arm_nxt;
  logic signed [15:0] upm_r, upm_nxt;
  logic [2:0]         phase_r, phase_nxt;

  logic signed [16:0] lim_pos, lim_neg, win_pos, win_neg;
  logic signed [16:0] arm_in_x, upm_x, drv_x;
  logic [16:0]        drv_mag;
  logic [9:0]         drv_duty;
  logic [1:0]         drv_dir;

  assign lim_pos  = $signed({2'b00, cfg.arm_safety_limit});
  assign lim_neg  = -lim_pos;
  assign win_pos  = $signed({2'b00, cfg.upright_window});
  assign win_neg  = -win_pos;
  assign arm_in_x = 17'(item.arm_angle_in);
  assign upm_x    = 17'(upm_r);
  assign drv_x    = 17'(item.drive_request);
  assign drv_mag  = drv_x[16] ? 17'(-drv_x) : 17'(drv_x);
  assign drv_duty = (drv_mag > 17'(cfg.pwm_limit)) ? cfg.pwm_limit : drv_mag[9:0];

  always_comb begin
    priority if (item.drive_request > 16'sd0) drv_dir = DIR_FORWARD;
    else if (item.drive_request < 16'sd0)     drv_dir = DIR_REVERSE;
    else                                      drv_dir = DIR_STOP;
  end

  always_comb begin
    started_nxt = started_r;
    pend_nxt    = pend_r;
    arm_nxt     = arm_r;
    upm_nxt     = upm_r;
    phase_nxt   = phase_r;
    res_valid   = 1'b0;
    res         = '{pwm_duty: '0, direction: DIR_STOP, direction_valid: 1'b1};

    if (item.command == CMD_ANGLE) begin
      pend_nxt = item.pendulum_angle;
      arm_nxt  = item.arm_angle_in;
      upm_nxt  = item.upright_measure;
      if (arm_in_x > lim_pos || arm_in_x < lim_neg) begin
        started_nxt = 1'b0;
        res_valid   = 1'b1;
      end
    end else if (item.stop_pressed) begin
      started_nxt = 1'b0;
      res_valid   = 1'b1;
    end else if (item.start_pressed || started_r) begin
      started_nxt = 1'b1;
      res_valid   = 1'b1;
      if (upm_x > win_neg && upm_x < win_pos) begin
        res = '{pwm_duty: drv_duty, direction: drv_dir, direction_valid: 1'b1};
      end else begin
        res.pwm_duty = cfg.swing_duty;
        unique case (phase_r)
          PH_ENTRY: begin
            phase_nxt           = PH_PUSH_FWD;
            res.direction       = DIR_NONE;
            res.direction_valid = 1'b0;
          end
          PH_PUSH_FWD: begin
            if (arm_r > cfg.swing_arm_threshold) phase_nxt = PH_WAIT_POS;
            res.direction = DIR_FORWARD;
          end
          PH_WAIT_POS: begin
            if (pend_r > 16'sd0) phase_nxt = PH_PUSH_REV;
          end
          PH_PUSH_REV: begin
            if (arm_r < 16'sd0) phase_nxt = PH_WAIT_NEG;
            res.direction = DIR_REVERSE;
          end
          PH_WAIT_NEG: begin
            if (pend_r < 16'sd0) phase_nxt = PH_PUSH_FWD;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      pend_r    <= '0;
      arm_r     <= '0;
      upm_r     <= '0;
      phase_r   <= PH_ENTRY;
    end else if (accept) begin
      started_r <= started_nxt;
      pend_r    <= pend_nxt;
      arm_r     <= arm_nxt;
      upm_r     <= upm_nxt;
      phase_r   <= phase_nxt;
    end
  end

endmodule

[hw/rtl/pmdc_out_buf.sv]
`timescale 1ns / 1ps

module pmdc_out_buf
  import pmdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  out_item_t wr_item,
  output logic      space,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      out_valid_r, skid_valid_r;
  out_item_t out_item_r, skid_item_r;
  logic      out_fire;

  assign out_fire = out_valid_r && out_ready;
  assign space    = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_item_r   <= skid_item_r;
        skid_valid_r <= 1'b0;
      end
    end else if (wr_en) begin
      if (!out_valid_r || out_fire) begin
        out_item_r  <= wr_item;
        out_valid_r <= 1'b1;
      end else begin
        skid_item_r  <= wr_item;
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[hw/rtl/pendulum_motor_drive_controller_top.sv]
`timescale 1ns / 1ps

// Pendulum rig motor drive controller. One item is taken per cycle while
// in_ready is high; its result, if any, is registered: all decisions are a single
// pass of compares from the item and the stored state, which updates in the
// accepting cycle. A two-entry output buffer keeps input acceptance going while a
// result is waiting; in_ready drops only when both entries are full. Angle items
// give a result only on a safety trip; button items give none while not started
// unless start or stop is pressed. Register writes take effect on the next edge.

module pendulum_motor_drive_controller_top
  import pmdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  out_item_t res;
  logic      res_valid;
  logic      space;
  logic      accept;

  assign in_ready = space;
  assign accept   = in_valid && space;

  pmdc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pmdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_item),
    .cfg       (cfg),
    .res       (res),
    .res_valid (res_valid)
  );

  pmdc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (accept && res_valid),
    .wr_item   (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
